>>> rtl/core/segment_endpoint_link_test_core_macros.svh
// Assertion macros used by the segment link test RTL
`ifndef SEGMENT_ENDPOINT_LINK_TEST_CORE_MACROS_SVH
`define SEGMENT_ENDPOINT_LINK_TEST_CORE_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds
`define SEGLT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment link test check failed");

// Check that cons holds in the cycle after ante
`define SEGLT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segment link test check failed");

`endif

>>> rtl/core/seglt_pkg.sv
// Shared types and constants for the segment endpoint link test
package seglt_pkg;

  localparam int COORD_BITS = 16;
  localparam int CW = (COORD_BITS < 16) ? COORD_BITS : 16;

  localparam int Q_DEPTH = 8;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  // one result bit per sqrt stage
  localparam int NSQ = 21;

  localparam logic [0:0] CFG_MAX_DIST = 1'b0;
  localparam logic [0:0] CFG_COS_THR = 1'b1;

  localparam logic [15:0] MAX_DIST_RST = 16'd150;
  localparam logic [14:0] COS_THR_RST = 15'd11469;

  typedef enum logic [1:0] {
    JOIN_SS = 2'd0,
    JOIN_SE = 2'd1,
    JOIN_ES = 2'd2,
    JOIN_EE = 2'd3
  } join_kind_t;

  // classified pair handed from front to back
  typedef struct packed {
    logic [32:0]        d2;
    logic signed [16:0] cx;
    logic signed [16:0] cy;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    join_kind_t         kind;
  } entry_t;

  typedef struct packed {
    logic       push;
    logic [1:0] inflight;
  } front_stat_t;

  function automatic logic signed [16:0] coord_hi(input logic [31:0] w);
    logic signed [CW-1:0] t;
    t = w[16+CW-1:16];
    return 17'(t);
  endfunction

  function automatic logic signed [16:0] coord_lo(input logic [31:0] w);
    logic signed [CW-1:0] t;
    t = w[CW-1:0];
    return 17'(t);
  endfunction

endpackage

>>> rtl/core/segment_endpoint_link_test_core.sv
// Top level of the segment endpoint link test engine
//
// Usage:
//   Input channel (in_*): one word per segment pair: endpoints and end
//   directions of segments A and B. Taken when in_valid is high and
//   in_stall low. in_stall rises only when the internal queue and the
//   front pipe together hold as many pairs as the queue can take.
//   Result channel (out_*): one word per pair, in order: link_valid,
//   link gap (Q17.4, floor of the exact gap) and join_kind.
//   Taken when out_valid is high and out_stall low.
//   Config channel (cfg_*): index 0 max_link_distance, 1 cos_threshold;
//   always ready, write only while no pairs are in flight.
// Timing: one pair per cycle sustained while in_stall and out_stall are low.
//   Pairs pass the front pipe, the queue and the back pipe (popped register
//   plus 21 root stages, one result bit each); the root pipe sets the latency.
// Reset: clears queue, pipe valid bits and loads the default limit (150)
//   and threshold (11469). While out_stall holds a finished word, the back
//   pipe freezes; the queue absorbs the front pipe, then in_stall rises.
`include "segment_endpoint_link_test_core_macros.svh"
module segment_endpoint_link_test_core import seglt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_a_start,
  input  logic [31:0] in_a_end,
  input  logic [31:0] in_a_start_dir,
  input  logic [31:0] in_a_end_dir,
  input  logic [31:0] in_b_start,
  input  logic [31:0] in_b_end,
  input  logic [31:0] in_b_start_dir,
  input  logic [31:0] in_b_end_dir,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_link_valid,
  output logic [20:0] out_link_gap,
  output logic [1:0]  out_join_kind,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [15:0] max_dist_r;
  logic [14:0] cos_thr_r;
  front_stat_t fstat;
  entry_t f_entry, q_entry;
  logic q_empty, q_pop;
  logic [Q_CW-1:0] q_cnt;
  logic in_acc;
  join_kind_t b_kind;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r <= MAX_DIST_RST;
      cos_thr_r <= COS_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_DIST: max_dist_r <= cfg_data[15:0];
        CFG_COS_THR:  cos_thr_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // credit check: queued plus in-flight pairs must fit in the queue
  assign in_stall = (({1'b0, q_cnt} + (Q_CW+1)'(fstat.inflight)) >= (Q_CW+1)'(Q_DEPTH));
  assign in_acc = in_valid && !in_stall;

  seglt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (in_acc),
    .a_start     (in_a_start),
    .a_end       (in_a_end),
    .a_start_dir (in_a_start_dir),
    .a_end_dir   (in_a_end_dir),
    .b_start     (in_b_start),
    .b_end       (in_b_end),
    .b_start_dir (in_b_start_dir),
    .b_end_dir   (in_b_end_dir),
    .stat        (fstat),
    .entry       (f_entry)
  );

  seglt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fstat.push),
    .wdata (f_entry),
    .pop   (q_pop),
    .rdata (q_entry),
    .empty (q_empty),
    .cnt   (q_cnt)
  );

  seglt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qdata      (q_entry),
    .qempty     (q_empty),
    .qpop       (q_pop),
    .max_dist   (max_dist_r),
    .cos_thr    (cos_thr_r),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .link_valid (out_link_valid),
    .gap        (out_link_gap),
    .kind       (b_kind)
  );

  assign out_join_kind = b_kind;

  `SEGLT_ASSERT_IMP(a_q_bound, 1'b1, q_cnt <= Q_CW'(Q_DEPTH))
  `SEGLT_ASSERT_IMP(a_full_stall, q_cnt == Q_CW'(Q_DEPTH), in_stall)
  `SEGLT_ASSERT_IMP(a_zero_gap, out_valid && out_link_gap == '0, !out_link_valid)
  `SEGLT_ASSERT_NXT(a_pop_nonempty, q_pop, $past(!q_empty))

endmodule

>>> rtl/core/seglt_front.sv
// Front end: endpoint gaps, squared lengths and selection of the nearest join
module seglt_front import seglt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [31:0] a_start,
  input  logic [31:0] a_end,
  input  logic [31:0] a_start_dir,
  input  logic [31:0] a_end_dir,
  input  logic [31:0] b_start,
  input  logic [31:0] b_end,
  input  logic [31:0] b_start_dir,
  input  logic [31:0] b_end_dir,
  output front_stat_t stat,
  output entry_t      entry
);

  logic [2:0] v_r;
  logic signed [16:0] cx1_r [4];
  logic signed [16:0] cy1_r [4];
  logic signed [16:0] cx2_r [4];
  logic signed [16:0] cy2_r [4];
  logic [32:0] d2_r [4];
  logic [31:0] dir1_r [4];
  logic [31:0] dir2_r [4];
  entry_t ent_r, ent_nxt;
  logic [31:0] apt [2];
  logic [31:0] bpt [2];

  assign apt[0] = a_start;
  assign apt[1] = a_end;
  assign bpt[0] = b_start;
  assign bpt[1] = b_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], acc};
    end
  end

  // stage 1: gaps; stage 2: squared lengths
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      cx1_r[k] <= coord_hi(apt[k/2]) - coord_hi(bpt[k%2]);
      cy1_r[k] <= coord_lo(apt[k/2]) - coord_lo(bpt[k%2]);
      cx2_r[k] <= cx1_r[k];
      cy2_r[k] <= cy1_r[k];
      d2_r[k]  <= 33'(cx1_r[k] * cx1_r[k]) + 33'(cy1_r[k] * cy1_r[k]);
      dir2_r[k] <= dir1_r[k];
    end
    dir1_r[0] <= a_start_dir;
    dir1_r[1] <= a_end_dir;
    dir1_r[2] <= b_start_dir;
    dir1_r[3] <= b_end_dir;
    ent_r <= ent_nxt;
  end

  // stage 3: smallest gap, earliest wins on a tie
  always_comb begin
    logic [1:0] best;
    logic [32:0] bd;
    best = 2'd0;
    bd = d2_r[0];
    for (int k = 1; k < 4; k++) begin
      if (d2_r[k] < bd) begin
        bd = d2_r[k];
        best = 2'(k);
      end
    end
    ent_nxt.d2   = bd;
    ent_nxt.cx   = cx2_r[best];
    ent_nxt.cy   = cy2_r[best];
    ent_nxt.ax   = dir2_r[{1'b0, best[1]}][31:16];
    ent_nxt.ay   = dir2_r[{1'b0, best[1]}][15:0];
    ent_nxt.bx   = dir2_r[{1'b1, best[0]}][31:16];
    ent_nxt.by   = dir2_r[{1'b1, best[0]}][15:0];
    ent_nxt.kind = join_kind_t'(best);
  end

  assign entry = ent_r;
  assign stat.push = v_r[2];
  assign stat.inflight = 2'({1'b0, v_r[0]} + {1'b0, v_r[1]} + {1'b0, v_r[2]});

endmodule

>>> rtl/core/seglt_queue.sv
// Short queue of classified pairs between front and back
module seglt_queue import seglt_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  entry_t          wdata,
  input  logic            pop,
  output entry_t          rdata,
  output logic            empty,
  output logic [Q_CW-1:0] cnt
);

  entry_t mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_CW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + Q_CW'(push) - Q_CW'(pop);
    end
  end

  assign rdata = mem_r[rp_r];
  assign empty = (cnt_r == '0);
  assign cnt = cnt_r;

endmodule

>>> rtl/core/seglt_back.sv
// Back end: angle and distance tests and a bit-per-stage square root
module seglt_back import seglt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  entry_t      qdata,
  input  logic        qempty,
  output logic        qpop,
  input  logic [15:0] max_dist,
  input  logic [14:0] cos_thr,
  input  logic        out_stall,
  output logic        out_valid,
  output logic        link_valid,
  output logic [20:0] gap,
  output join_kind_t  kind
);

  logic adv;
  logic b0_v_r;
  entry_t b0_r;

  logic [NSQ-1:0] v_r;
  logic [23:0] rem_r [NSQ];
  logic [23:0] rem_nxt [NSQ];
  logic [20:0] root_r [NSQ];
  logic [20:0] root_nxt [NSQ];
  logic [41:0] nsh_r [NSQ];
  logic [41:0] nsh_nxt [NSQ];
  join_kind_t kind_r [NSQ];
  logic okp_r [NSQ-2];

  // angle stage 1
  logic signed [34:0] dotn_r, pa_r, pb_r;
  logic [29:0] thr2_r;
  logic [31:0] lim_r;
  logic [32:0] d2c_r;
  // angle stage 2
  logic dir_ok_r, dist_ok_r, pa_pos_r, pb_pos_r;
  logic [31:0] ahh_r, bhh_r;
  logic [32:0] ahl_r, bhl_r;
  logic [33:0] all_r, bll_r;
  logic [45:0] rh_r;
  logic [46:0] rl_r;

  logic signed [31:0] p1, p2;
  logic signed [32:0] q1, q2, r1, r2;
  logic [32:0] pam, pbm;
  logic [65:0] lhs_a, lhs_b, rhs;

  // whole pipe holds while a finished word waits
  assign adv = !(v_r[NSQ-1] && out_stall);
  assign qpop = adv && !qempty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r <= 1'b0;
      v_r <= '0;
    end else if (adv) begin
      b0_v_r <= !qempty;
      v_r <= {v_r[NSQ-2:0], b0_v_r};
    end
  end

  always_comb begin
    for (int s = 0; s < NSQ; s++) begin
      logic [23:0] rsh, trial;
      logic [23:0] rin;
      logic [20:0] rtin;
      logic [41:0] nin;
      if (s == 0) begin
        rin = '0;
        rtin = '0;
        nin = {1'b0, b0_r.d2, 8'd0};
      end else begin
        rin = rem_r[s-1];
        rtin = root_r[s-1];
        nin = nsh_r[s-1];
      end
      rsh = {rin[21:0], nin[41:40]};
      trial = {1'b0, rtin, 2'b01};
      if (rsh >= trial) begin
        rem_nxt[s] = rsh - trial;
        root_nxt[s] = {rtin[19:0], 1'b1};
      end else begin
        rem_nxt[s] = rsh;
        root_nxt[s] = {rtin[19:0], 1'b0};
      end
      nsh_nxt[s] = {nin[39:0], 2'b00};
    end
  end

  assign p1 = b0_r.ax * b0_r.bx;
  assign p2 = b0_r.ay * b0_r.by;
  assign q1 = b0_r.ax * b0_r.cx;
  assign q2 = b0_r.ay * b0_r.cy;
  assign r1 = b0_r.bx * b0_r.cx;
  assign r2 = b0_r.by * b0_r.cy;
  assign pam = pa_r[32:0];
  assign pbm = pb_r[32:0];

  assign lhs_a = (66'(ahh_r) << 34) + (66'(ahl_r) << 18) + 66'(all_r);
  assign lhs_b = (66'(bhh_r) << 34) + (66'(bhl_r) << 18) + 66'(bll_r);
  assign rhs = (66'(rh_r) << 17) + 66'(rl_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (qpop) b0_r <= qdata;
      for (int s = 0; s < NSQ; s++) begin
        rem_r[s] <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
        nsh_r[s] <= nsh_nxt[s];
      end
      kind_r[0] <= b0_r.kind;
      for (int s = 1; s < NSQ; s++) kind_r[s] <= kind_r[s-1];
      // dot products and squared limits
      dotn_r <= -(35'(p1) + 35'(p2));
      pa_r <= -(35'(q1) + 35'(q2));
      pb_r <= 35'(r1) + 35'(r2);
      thr2_r <= cos_thr * cos_thr;
      lim_r <= max_dist * max_dist;
      d2c_r <= b0_r.d2;
      // compares and partial products
      dir_ok_r <= dotn_r > $signed({6'd0, cos_thr, 14'd0});
      dist_ok_r <= (d2c_r != '0) && (d2c_r <= {1'b0, lim_r});
      pa_pos_r <= pa_r > 35'sd0;
      pb_pos_r <= pb_r > 35'sd0;
      ahh_r <= pam[32:17] * pam[32:17];
      ahl_r <= pam[32:17] * pam[16:0];
      all_r <= pam[16:0] * pam[16:0];
      bhh_r <= pbm[32:17] * pbm[32:17];
      bhl_r <= pbm[32:17] * pbm[16:0];
      bll_r <= pbm[16:0] * pbm[16:0];
      rh_r <= thr2_r * d2c_r[32:17];
      rl_r <= thr2_r * d2c_r[16:0];
      // final verdict joins the root pipe at its third stage
      okp_r[0] <= dir_ok_r && dist_ok_r && pa_pos_r && pb_pos_r &&
                  (lhs_a > rhs) && (lhs_b > rhs);
      for (int j = 1; j < NSQ-2; j++) okp_r[j] <= okp_r[j-1];
    end
  end

  assign out_valid = v_r[NSQ-1];
  assign link_valid = okp_r[NSQ-3];
  assign gap = root_r[NSQ-1];
  assign kind = kind_r[NSQ-1];

endmodule

>>> test/segment_endpoint_link_checker.sv
// Checker for the segment link test: predicts each result word and compares it
`timescale 1ns / 100ps
module segment_endpoint_link_checker import seglt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_a_start,
  input  logic [31:0] in_a_end,
  input  logic [31:0] in_a_start_dir,
  input  logic [31:0] in_a_end_dir,
  input  logic [31:0] in_b_start,
  input  logic [31:0] in_b_end,
  input  logic [31:0] in_b_start_dir,
  input  logic [31:0] in_b_end_dir,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_link_valid,
  input  logic [20:0] out_link_gap,
  input  logic [1:0]  out_join_kind,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic        link;
    logic [20:0] gap;
    join_kind_t  kind;
  } link_word_t;

  link_word_t  link_q[$];
  logic [15:0] lim_reg;
  logic [14:0] thr_reg;

  initial pending = 0;

  function automatic longint coord(input logic [15:0] h);
    logic signed [CW-1:0] t;
    t = h[CW-1:0];
    return longint'(t);
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // p > thr * sqrt(d2), done exactly in 128 bits
  function automatic bit cos_ok(input longint p, input logic [63:0] d2,
                                input logic [14:0] thr);
    logic [127:0] lhs, rhs;
    if (p <= 0) return 0;
    lhs = 128'(p) * 128'(p);
    rhs = 128'(thr) * 128'(thr) * 128'(d2);
    return lhs > rhs;
  endfunction

  function automatic link_word_t predict_link(input logic [31:0] ap0, ap1, ad0, ad1,
                                              bp0, bp1, bd0, bd1);
    logic [31:0] ap[2], bp[2], ad[2], bd[2];
    longint cx[4], cy[4];
    logic [63:0] d2[4], best_d2, root_v;
    longint ax, ay, bx, by, dot;
    int best;
    bit ok;
    link_word_t w;
    ap = '{ap0, ap1}; bp = '{bp0, bp1}; ad = '{ad0, ad1}; bd = '{bd0, bd1};
    best = 0;
    for (int k = 0; k < 4; k++) begin
      cx[k] = coord(ap[k >> 1][31:16]) - coord(bp[k & 1][31:16]);
      cy[k] = coord(ap[k >> 1][15:0]) - coord(bp[k & 1][15:0]);
      d2[k] = cx[k] * cx[k] + cy[k] * cy[k];
    end
    best_d2 = d2[0];
    for (int k = 1; k < 4; k++)
      if (d2[k] < best_d2) begin
        best_d2 = d2[k];
        best = k;
      end
    root_v = root64(best_d2 << 8);
    if (root_v > 64'd2097151) root_v = 64'd2097151;
    ok = best_d2 != 0 && best_d2 <= 64'(lim_reg) * 64'(lim_reg);
    ax = longint'($signed(ad[best >> 1][31:16]));
    ay = longint'($signed(ad[best >> 1][15:0]));
    bx = longint'($signed(bd[best & 1][31:16]));
    by = longint'($signed(bd[best & 1][15:0]));
    dot = ax * bx + ay * by;
    if (!(-dot > (longint'(thr_reg) << 14))) ok = 0;
    if (!cos_ok(-(ax * cx[best] + ay * cy[best]), best_d2, thr_reg)) ok = 0;
    if (!cos_ok(bx * cx[best] + by * cy[best], best_d2, thr_reg)) ok = 0;
    w.link = ok;
    w.gap = root_v[20:0];
    w.kind = join_kind_t'(best[1:0]);
    return w;
  endfunction

  always @(posedge clk) begin
    link_word_t exp_w;
    if (!rst_n) begin
      lim_reg <= MAX_DIST_RST;
      thr_reg <= COS_THR_RST;
      link_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAX_DIST) lim_reg <= cfg_data[15:0];
        else thr_reg <= cfg_data[14:0];
      end
      if (in_valid && !in_stall)
        link_q = {link_q, predict_link(in_a_start, in_a_end, in_a_start_dir, in_a_end_dir,
                                       in_b_start, in_b_end, in_b_start_dir, in_b_end_dir)};
      if (out_valid && !out_stall) begin
        if (link_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result word at %0t", $realtime);
        end else begin
          exp_w = link_q.pop_front();
          if (exp_w.link !== out_link_valid || exp_w.gap !== out_link_gap ||
              exp_w.kind !== out_join_kind) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp link %0d gap %0d kind %0d, got %0d %0d %0d",
                       exp_w.link, exp_w.gap, exp_w.kind,
                       out_link_valid, out_link_gap, out_join_kind);
          end
        end
      end
    end
    pending = link_q.size();
  end

endmodule

>>> test/segment_endpoint_link_test_core_tb.sv
// Testbench top for the segment endpoint link test engine
`timescale 1ns / 100ps
module segment_endpoint_link_test_core_tb import seglt_pkg::*;;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [31:0] in_a_start = 0, in_a_end = 0, in_a_start_dir = 0, in_a_end_dir = 0;
  logic [31:0] in_b_start = 0, in_b_end = 0, in_b_start_dir = 0, in_b_end_dir = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        out_link_valid;
  logic [20:0] out_link_gap;
  logic [1:0]  out_join_kind;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = CFG_MAX_DIST;
  logic [31:0] cfg_data = 0;
  int          fail_count;
  int          pending;
  int          cycle_cnt = 0;
  bit          hold_off = 0;   // set by the stimulus to force a long receiver stall

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  always #5 clk = ~clk;

  segment_endpoint_link_test_core u_top (.*);

  segment_endpoint_link_checker u_chk (.*);

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: stalls on its own pattern; in hold-off mode stalls solid
  initial begin
    int mode;
    forever begin
      @(negedge clk);
      mode = (cycle_cnt / 500) % 4;
      if (hold_off) out_stall <= 1;
      else if (mode == 0) out_stall <= 0;
      else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
      else if (mode == 2) out_stall <= ($urandom_range(0, 1) == 0);
      else out_stall <= ($urandom_range(0, 9) < 7);
    end
  end

  function automatic logic [31:0] pack_pt(input int x, input int y);
    return {x[15:0], y[15:0]};
  endfunction

  // Random unit-ish direction at a random angle; sometimes pure noise
  function automatic logic [31:0] rand_dir();
    int ang;
    real c, s;
    if ($urandom_range(0, 7) == 0) return $urandom;
    ang = $urandom_range(0, 359);
    c = $cos(ang * 3.14159265 / 180.0) * 16384.0;
    s = $sin(ang * 3.14159265 / 180.0) * 16384.0;
    return pack_pt(int'(c), int'(s));
  endfunction

  // Send one word; hold it steady through any stall
  task automatic send_pair(input logic [31:0] as, ae, asd, aed, bs, be, bsd, bed);
    in_a_start <= as; in_a_end <= ae; in_a_start_dir <= asd; in_a_end_dir <= aed;
    in_b_start <= bs; in_b_end <= be; in_b_start_dir <= bsd; in_b_end_dir <= bed;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_input(input int n);
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Wait until every expected word is back, then let the pipe settle
  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  // Pair with B near one end of A and random directions; sometimes pure noise
  task automatic send_random_pair(input int spread);
    int x0, y0, x1, y1, x2, y2, x3, y3;
    x0 = $urandom_range(0, 2000) - 1000; y0 = $urandom_range(0, 2000) - 1000;
    x1 = x0 + $urandom_range(0, 400) - 200; y1 = y0 + $urandom_range(0, 400) - 200;
    x2 = x1 + $urandom_range(0, 2 * spread) - spread;
    y2 = y1 + $urandom_range(0, 2 * spread) - spread;
    x3 = x2 + $urandom_range(0, 400) - 200; y3 = y2 + $urandom_range(0, 400) - 200;
    if ($urandom_range(0, 9) == 0)
      send_pair($urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
    else if ($urandom_range(0, 1) == 0)
      send_pair(pack_pt(x0, y0), pack_pt(x1, y1), rand_dir(), rand_dir(),
                pack_pt(x2, y2), pack_pt(x3, y3), rand_dir(), rand_dir());
    else
      send_pair(pack_pt(x3, y3), pack_pt(x2, y2), rand_dir(), rand_dir(),
                pack_pt(x1, y1), pack_pt(x0, y0), rand_dir(), rand_dir());
  endtask

  initial begin
    logic [31:0] east, west;
    int sent, burst;
    east = pack_pt(16384, 0);
    west = pack_pt(-16384, 0);
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: collinear end-to-start link, passes at defaults
    send_pair(pack_pt(0, 0), pack_pt(100, 0), west, east,
              pack_pt(110, 0), pack_pt(200, 0), west, east);
    // the other three join kinds in turn
    send_pair(pack_pt(10, 0), pack_pt(100, 0), west, east,
              pack_pt(0, 0), pack_pt(-90, 0), east, west);
    send_pair(pack_pt(10, 0), pack_pt(100, 0), west, east,
              pack_pt(-90, 0), pack_pt(0, 0), west, east);
    send_pair(pack_pt(0, 0), pack_pt(100, 0), west, east,
              pack_pt(300, 0), pack_pt(110, 0), east, west);
    // zero gap, all four gaps tie
    send_pair(pack_pt(5, 5), pack_pt(5, 5), west, east, pack_pt(5, 5), pack_pt(5, 5),
              west, east);
    // extreme coordinates and maximum gap, then all-ones and all-zeros words
    send_pair(pack_pt(-32768, -32768), pack_pt(-32768, -32768), 32'h8000_8000, 32'h7fff_7fff,
              pack_pt(32767, 32767), pack_pt(32767, 32767), 32'h7fff_7fff, 32'h8000_8000);
    send_pair(32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0, 32'h0, 32'hffff_ffff,
              32'h0, 32'hffff_ffff);
    // gap exactly at the limit and just over
    send_pair(pack_pt(0, 0), pack_pt(100, 0), west, east,
              pack_pt(250, 0), pack_pt(400, 0), west, east);
    send_pair(pack_pt(0, 0), pack_pt(100, 0), west, east,
              pack_pt(251, 0), pack_pt(400, 0), west, east);
    // non-unit and bent directions
    send_pair(pack_pt(0, 0), pack_pt(100, 0), west, pack_pt(20000, 3000),
              pack_pt(110, 3), pack_pt(200, 0), pack_pt(16000, 2000), east);
    drain();

    // Sweep register extremes between phases
    write_reg(CFG_MAX_DIST, 32'd0);
    write_reg(CFG_COS_THR, 32'd0);
    repeat (8) send_random_pair(60);
    drain();
    write_reg(CFG_MAX_DIST, 32'hffff);
    write_reg(CFG_COS_THR, 32'h7fff);
    repeat (8) send_random_pair(60);
    drain();
    write_reg(CFG_COS_THR, 32'd16384);
    repeat (4) send_random_pair(60);
    drain();

    // Random phases with varied settings and bursty sender
    sent = 0;
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_MAX_DIST, (ph == 0) ? 32'd150 : $urandom_range(0, 65535) & 32'h3ff);
      write_reg(CFG_COS_THR, (ph == 4) ? 32'd0 : $urandom_range(6000, 16384));
      for (int n = 0; n < 400; n += burst) begin
        burst = $urandom_range(1, 30);
        for (int j = 0; j < burst; j++) send_random_pair((j % 5 == 0) ? 2000 : 80);
        if ($urandom_range(0, 3) != 0) idle_input($urandom_range(0, 12));
        // hold the receiver off while the sender keeps going so the queue fills
        if (ph == 2 && n == 0) begin
          hold_off = 1;
          fork
            begin repeat (200) @(negedge clk); hold_off = 0; end
            repeat (60) send_random_pair(80);
          join
        end
      end
      // sender pause until all results are back
      drain();
    end

    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/seglt_pkg.sv
rtl/core/seglt_front.sv
rtl/core/seglt_queue.sv
rtl/core/seglt_back.sv
rtl/core/segment_endpoint_link_test_core.sv
test/segment_endpoint_link_checker.sv
test/segment_endpoint_link_test_core_tb.sv
